// ===== sv/ddrt_pkg.sv =====
// Shared types, sizes and codes for the dependency ready tracker.
// Depends on nothing; every other file of the block imports it.
package ddrt_pkg;

   // Graph sizes
   localparam int NUM_TASKS  = 1024;
   localparam int MAX_FANOUT = 64;

   // Field widths fixed by the interface
   localparam int TASK_W  = 10;
   localparam int PEND_W  = 17;

   // Storage sizes derived from the graph sizes
   localparam int MEM_TASKS = (NUM_TASKS < (1 << TASK_W)) ? NUM_TASKS : (1 << TASK_W);
   localparam int IDX_W     = (MEM_TASKS > 1) ? $clog2(MEM_TASKS) : 1;
   localparam int COUNT_W   = $clog2(MAX_FANOUT + 1);
   localparam int TBL_DEPTH = MEM_TASKS * MAX_FANOUT;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   // Operation codes
   localparam logic OP_ADD_EDGE  = 1'b0;
   localparam logic OP_MARK_DONE = 1'b1;

   // Result kinds and edge status codes
   localparam logic KIND_EDGE_STATUS = 1'b0;
   localparam logic KIND_READY       = 1'b1;
   localparam logic STATUS_ADDED     = 1'b0;
   localparam logic STATUS_DROPPED   = 1'b1;

   typedef struct packed {
      logic              op;
      logic [TASK_W-1:0] src_task;
      logic [TASK_W-1:0] dst_task;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic              status;
      logic [TASK_W-1:0] ready_task;
      logic              last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;      // load the request fields
      logic clear_en;     // clear one counter row
      logic add_commit;   // write back an edge add
      logic emit_status;  // load the edge status result
      logic walk_start;   // load the list length, zero the walk index
      logic walk_latch;   // take the successor from the table read
      logic walk_commit;  // finish one successor step
      logic flush;        // send the held ready report as the last one
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic op_mark;
      logic src_ok;
      logic count_zero;
      logic out_free;
      logic held_valid;
      logic hit;
      logic walk_last_idx;
   } stat_type;

   function automatic logic task_in_range(input logic [TASK_W-1:0] t);
      return 32'(t) < NUM_TASKS;
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [IDX_W-1:0]   t,
                                                  input logic [COUNT_W-1:0] slot);
      return TBL_AW'(t) * TBL_AW'(MAX_FANOUT) + TBL_AW'(slot);
   endfunction

endpackage

// ===== sv/ddrt_datapath.sv =====
// Datapath: successor table, list counters, in-degree counters, result buffering.
// Depends on ddrt_pkg; driven by ddrt_ctrl through command and status structs.
module ddrt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ddrt_pkg::req_type req_data,
   input  ddrt_pkg::cmd_type cmd,
   output ddrt_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ddrt_pkg::rsp_type rsp_data
);
   import ddrt_pkg::*;

   // Memories
   logic [COUNT_W-1:0] cnt_mem  [MEM_TASKS];
   logic [PEND_W-1:0]  pend_mem [MEM_TASKS];
   logic [TASK_W-1:0]  tbl_mem  [TBL_DEPTH];

   // Request and walk registers
   logic               op_ff;
   logic [TASK_W-1:0]  src_ff;
   logic [TASK_W-1:0]  task_b_ff;
   logic [COUNT_W-1:0] n_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic [IDX_W-1:0]   clear_addr_ff;

   // Registered read data
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [PEND_W-1:0]  pend_rd_ff;
   logic [TASK_W-1:0]  tbl_rd_ff;

   // Result buffering
   logic [TASK_W-1:0]  held_ff;
   logic               held_valid_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               src_ok;
   logic               dst_ok;
   logic               full;
   logic               add_ok;
   logic               skip;
   logic               hit;
   logic               out_free;
   logic               emit_held;
   logic               cnt_we;
   logic               pend_we;
   logic [IDX_W-1:0]   src_idx;
   logic [IDX_W-1:0]   pend_raddr;
   logic [IDX_W-1:0]   pend_waddr;
   logic [PEND_W-1:0]  pend_wdata;
   logic [COUNT_W-1:0] cnt_wdata;
   logic [IDX_W-1:0]   cnt_waddr;

   // Decode the current step
   assign src_idx  = src_ff[IDX_W-1:0];
   assign src_ok   = task_in_range(src_ff);
   assign dst_ok   = task_in_range(task_b_ff);
   assign full     = cnt_rd_ff >= COUNT_W'(MAX_FANOUT);
   assign add_ok   = src_ok && dst_ok && !full;
   assign skip     = !dst_ok || (pend_rd_ff == '0);
   assign hit      = !skip && (pend_rd_ff == PEND_W'(1));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_held = (cmd.walk_commit && hit && held_valid_ff) || cmd.flush;

   assign stat.clear_done    = clear_addr_ff == IDX_W'(MEM_TASKS - 1);
   assign stat.op_mark       = op_ff == OP_MARK_DONE;
   assign stat.src_ok        = src_ok;
   assign stat.count_zero    = cnt_rd_ff == '0;
   assign stat.out_free      = out_free;
   assign stat.held_valid    = held_valid_ff;
   assign stat.hit           = hit;
   assign stat.walk_last_idx = (idx_ff + COUNT_W'(1)) == n_ff;

   // Select counter write ports
   always_comb begin
      cnt_we     = cmd.clear_en || (cmd.add_commit && add_ok);
      cnt_waddr  = cmd.clear_en ? clear_addr_ff : src_idx;
      cnt_wdata  = cmd.clear_en ? '0 : cnt_rd_ff + COUNT_W'(1);
      pend_we    = cmd.clear_en || (cmd.add_commit && add_ok) || (cmd.walk_commit && !skip);
      pend_waddr = cmd.clear_en ? clear_addr_ff : task_b_ff[IDX_W-1:0];
      pend_raddr = cmd.walk_latch ? tbl_rd_ff[IDX_W-1:0] : task_b_ff[IDX_W-1:0];
      if (cmd.clear_en) begin
         pend_wdata = '0;
      end else if (cmd.add_commit) begin
         pend_wdata = (pend_rd_ff < PEND_MAX) ? pend_rd_ff + PEND_W'(1) : pend_rd_ff;
      end else begin
         pend_wdata = pend_rd_ff - PEND_W'(1);
      end
   end

   // Successor list lengths
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[src_idx];
   end

   // In-degree counters
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= pend_wdata;
      end
      pend_rd_ff <= pend_mem[pend_raddr];
   end

   // Successor table: append at the list end, read at the walk index
   always_ff @(posedge clock) begin
      if (cmd.add_commit && add_ok) begin
         tbl_mem[tbl_addr(src_idx, cnt_rd_ff)] <= task_b_ff;
      end
      tbl_rd_ff <= tbl_mem[tbl_addr(src_idx, idx_ff)];
   end

   // Hold request fields and advance the walk
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_data.op;
         src_ff    <= req_data.src_task;
         task_b_ff <= req_data.dst_task;
      end else if (cmd.walk_latch) begin
         task_b_ff <= tbl_rd_ff;
      end
      if (cmd.walk_start) begin
         n_ff   <= (cnt_rd_ff > COUNT_W'(MAX_FANOUT)) ? COUNT_W'(MAX_FANOUT) : cnt_rd_ff;
         idx_ff <= '0;
      end else if (cmd.walk_commit) begin
         idx_ff <= idx_ff + COUNT_W'(1);
      end
   end

   // Sweep the counter rows after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_en) begin
         clear_addr_ff <= clear_addr_ff + IDX_W'(1);
      end
   end

   // Keep the newest ready task back until the next one, or the end, is known
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.walk_commit && hit) begin
         held_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         held_valid_ff <= 1'b0;
      end
      if (cmd.walk_commit && hit) begin
         held_ff <= task_b_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_status || emit_held) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_status) begin
         rsp_ff.kind       <= KIND_EDGE_STATUS;
         rsp_ff.status     <= add_ok ? STATUS_ADDED : STATUS_DROPPED;
         rsp_ff.ready_task <= '0;
         rsp_ff.last       <= 1'b1;
      end else if (emit_held) begin
         rsp_ff.kind       <= KIND_READY;
         rsp_ff.status     <= STATUS_ADDED;
         rsp_ff.ready_task <= held_ff;
         rsp_ff.last       <= cmd.flush;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/ddrt_ctrl.sv =====
// Controller state machine: sequences clearing, edge adds and successor walks.
// Depends on ddrt_pkg; commands ddrt_datapath and reads its status.
module ddrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ddrt_pkg::stat_type stat,
   output ddrt_pkg::cmd_type  cmd
);
   import ddrt_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ADD_DECIDE,
      ST_DONE_START,
      ST_WALK_TBL,
      ST_WALK_PEND,
      ST_WALK_UPD,
      ST_WALK_END
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      step_ok;

   // A new ready task can only displace the held one when the output is free
   assign step_ok = !(stat.hit && stat.held_valid && !stat.out_free);

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = stat.op_mark ? ST_DONE_START : ST_ADD_DECIDE;
         end
         ST_ADD_DECIDE: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               cmd.add_commit  = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_DONE_START: begin
            cmd.walk_start = 1'b1;
            state_in = (!stat.src_ok || stat.count_zero) ? ST_IDLE : ST_WALK_TBL;
         end
         ST_WALK_TBL: begin
            state_in = ST_WALK_PEND;
         end
         ST_WALK_PEND: begin
            cmd.walk_latch = 1'b1;
            state_in       = ST_WALK_UPD;
         end
         ST_WALK_UPD: begin
            if (step_ok) begin
               cmd.walk_commit = 1'b1;
               state_in = stat.walk_last_idx ? ST_WALK_END : ST_WALK_TBL;
            end
         end
         ST_WALK_END: begin
            if (!stat.held_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/dag_dependency_ready_tracker_top.sv =====
// Dependency ready tracker: an add edge passes lookup and decide states, then
// its result is registered; a new request is taken only after the last is done.
// A mark done starts its walk, does one table read, one counter read and one
// counter write per successor, then ends; a result stall lengthens it.
// Up to 64 ready reports per mark done. Synchronous reset starts a clearing
// pass over the 1024 counter rows; no request is accepted until it ends.
module dag_dependency_ready_tracker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ddrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ddrt_pkg::rsp_type rsp_data
);
   import ddrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ddrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/ddrt_checker.sv =====
// Port-level checks for the dependency ready tracker, bound to its top level.
// Depends on ddrt_pkg.
module ddrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ddrt_pkg::rsp_type rsp_data
);
   import ddrt_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Edge status is always a single, final result with no task
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_EDGE_STATUS) |->
         rsp_data.last && (rsp_data.ready_task == '0))
      else $error("malformed edge status result");

   // Ready reports carry a zero status
   a_ready_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_READY) |-> rsp_data.status == STATUS_ADDED)
      else $error("ready report with nonzero status");

   // Reset drops pending results and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

endmodule

bind dag_dependency_ready_tracker_top ddrt_checker u_checker (.*);

// ===== tb/dag_dependency_ready_tracker_top_tb.sv =====
// Self-checking testbench for the dependency ready tracker top level.
// Depends on ddrt_pkg and dag_dependency_ready_tracker_top; a built-in graph predictor
// checks the untyped directed rows and every result of random graph-building episodes.
module dag_dependency_ready_tracker_top_tb;
   import ddrt_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 200;
   localparam int QUIET_AFTER  = 160;
   localparam int DRAIN_WAIT   = 250;
   localparam int N_DIR        = 16;

   typedef struct packed {
      req_type req;
      logic    typed;    // expectation typed into the row
      logic    has_rsp;  // typed row causes one result
      rsp_type exp_rsp;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predictor state: successor lists, their lengths and in-degrees
   logic [TASK_W-1:0] fanout_list [NUM_TASKS][MAX_FANOUT];
   int                fanout_cnt  [NUM_TASKS];
   logic [PEND_W-1:0] indegree    [NUM_TASKS];

   rsp_type     step_rsps [$];
   rsp_type     exp_rsps  [$];
   dir_row_type dir_rows  [N_DIR];

   int cycle_count  = 0;
   int err_count    = 0;
   int random_items = 0;
   int rsp_stall    = 0;
   bit quiet        = 1'b0;
   bit req_bursty   = 1'b0;
   bit rsp_bursty   = 1'b0;
   int n_adds       = 0;
   int n_marks      = 0;
   int n_dropped    = 0;
   int n_ready      = 0;
   int max_burst    = 0;

   dag_dependency_ready_tracker_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, exp_rsps.size());
         $display("dag_dependency_ready_tracker_top_tb: FAIL");
         $finish;
      end
   end

   function automatic rsp_type edge_status(input logic st);
      rsp_type r;
      r.kind       = KIND_EDGE_STATUS;
      r.status     = st;
      r.ready_task = '0;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic rsp_type ready_report(input logic [TASK_W-1:0] node, input logic lst);
      rsp_type r;
      r.kind       = KIND_READY;
      r.status     = STATUS_ADDED;
      r.ready_task = node;
      r.last       = lst;
      return r;
   endfunction

   function automatic dir_row_type row(input logic op, input int src, input int dst,
                                       input logic typed, input logic has_rsp,
                                       input rsp_type exp_rsp);
      dir_row_type d;
      d.req.op       = op;
      d.req.src_task = TASK_W'(src);
      d.req.dst_task = TASK_W'(dst);
      d.typed        = typed;
      d.has_rsp      = has_rsp;
      d.exp_rsp      = exp_rsp;
      return d;
   endfunction

   // Compute the results of one transaction and update the graph copy
   task automatic predict_item(input req_type r);
      logic [TASK_W-1:0] node;
      logic [TASK_W-1:0] ready_nodes [$];
      step_rsps.delete();
      if (r.op == OP_ADD_EDGE) begin
         n_adds++;
         if (int'(r.src_task) >= NUM_TASKS || int'(r.dst_task) >= NUM_TASKS ||
             fanout_cnt[r.src_task] >= MAX_FANOUT) begin
            step_rsps.push_back(edge_status(STATUS_DROPPED));
            n_dropped++;
         end else begin
            fanout_list[r.src_task][fanout_cnt[r.src_task]] = r.dst_task;
            fanout_cnt[r.src_task]++;
            if (indegree[r.dst_task] != PEND_MAX)
               indegree[r.dst_task] = indegree[r.dst_task] + 1'b1;
            step_rsps.push_back(edge_status(STATUS_ADDED));
         end
      end else begin
         n_marks++;
         if (int'(r.src_task) < NUM_TASKS) begin
            // walk successors in insertion order; a zero count stays at zero
            for (int i = 0; i < fanout_cnt[r.src_task]; i++) begin
               node = fanout_list[r.src_task][i];
               if (int'(node) < NUM_TASKS && indegree[node] != '0) begin
                  indegree[node] = indegree[node] - 1'b1;
                  if (indegree[node] == '0)
                     ready_nodes.push_back(node);
               end
            end
         end
         foreach (ready_nodes[i])
            step_rsps.push_back(ready_report(ready_nodes[i],
                                             i == ready_nodes.size() - 1));
         n_ready += ready_nodes.size();
         if (ready_nodes.size() > max_burst)
            max_burst = ready_nodes.size();
      end
   endtask

   // Present one transaction, hold it until accepted, then queue its results
   task automatic send_item(input req_type r, input logic typed, input logic has_rsp,
                            input rsp_type typed_rsp);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_item(r);
      if (typed) begin
         if (has_rsp)
            exp_rsps.push_back(typed_rsp);
      end else begin
         foreach (step_rsps[i])
            exp_rsps.push_back(step_rsps[i]);
      end
   endtask

   task automatic idle_req(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1)
         @(negedge clock);
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain();
      idle_req(1);
      while (exp_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_rand(input logic op, input int src, input int dst);
      req_type r;
      r.op       = op;
      r.src_task = TASK_W'(src);
      r.dst_task = TASK_W'(dst);
      send_item(r, 1'b0, 1'b0, '0);
      random_items++;
      quiet = (random_items >= QUIET_AFTER);
      if (!quiet && req_bursty && $urandom_range(0, 4) == 0)
         idle_req($urandom_range(1, 8));
   endtask

   task automatic send_noise();
      send_rand(logic'($urandom_range(0, 1)), $urandom_range(0, NUM_TASKS - 1),
                $urandom_range(0, NUM_TASKS - 1));
   endtask

   // Fill one successor list past its limit, release all of it, then add to it once more
   task automatic fanout_episode();
      int src;
      int dbase;
      src   = $urandom_range(0, NUM_TASKS - 1);
      dbase = $urandom_range(0, NUM_TASKS - MAX_FANOUT);
      for (int i = 0; i < MAX_FANOUT + 3; i++)
         send_rand(OP_ADD_EDGE, src, dbase + (i % MAX_FANOUT));
      send_rand(OP_MARK_DONE, src, $urandom_range(0, NUM_TASKS - 1));
      send_rand(OP_ADD_EDGE, src, $urandom_range(0, NUM_TASKS - 1));
   endtask

   // Build a small graph over eight neighboring tasks, then retire its nodes
   task automatic graph_episode();
      int base;
      base = $urandom_range(0, NUM_TASKS - 8);
      repeat ($urandom_range(4, 14)) begin
         if ($urandom_range(0, 7) == 0)
            send_noise();
         else if ($urandom_range(0, 5) == 0)
            send_rand(OP_MARK_DONE, base + $urandom_range(0, 7),
                      $urandom_range(0, NUM_TASKS - 1));
         else
            send_rand(OP_ADD_EDGE, base + $urandom_range(0, 7), base + $urandom_range(0, 7));
      end
      repeat ($urandom_range(3, 10)) begin
         if ($urandom_range(0, 7) == 0)
            send_noise();
         else
            send_rand(OP_MARK_DONE, base + $urandom_range(0, 7),
                      $urandom_range(0, NUM_TASKS - 1));
      end
   endtask

   // Result side: random stall bursts, none in the closing stretch
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (quiet || !rsp_bursty || $urandom_range(0, 5) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_rsps.size() == 0) begin
            if (err_count < 10)
               $display("unexpected result: kind=%0d status=%0d task=%0d last=%0d",
                        rsp_data.kind, rsp_data.status, rsp_data.ready_task, rsp_data.last);
            err_count++;
         end else begin
            e = exp_rsps.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.status !== e.status ||
                rsp_data.ready_task !== e.ready_task || rsp_data.last !== e.last) begin
               if (err_count < 10) begin
                  $display("mismatch: expected kind=%0d status=%0d task=%0d last=%0d",
                           e.kind, e.status, e.ready_task, e.last);
                  $display("          got      kind=%0d status=%0d task=%0d last=%0d",
                           rsp_data.kind, rsp_data.status, rsp_data.ready_task,
                           rsp_data.last);
               end
               err_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         fanout_cnt[i] = 0;
         indegree[i]   = '0;
      end

      // Directed table: extremes, self loop, duplicates, zero counts, empty lists
      dir_rows[0]  = row(OP_ADD_EDGE,  0,    1023, 1, 1, edge_status(STATUS_ADDED));
      dir_rows[1]  = row(OP_ADD_EDGE,  1023, 0,    1, 1, edge_status(STATUS_ADDED));
      dir_rows[2]  = row(OP_MARK_DONE, 1023, 1023, 1, 1, ready_report(10'd0, 1'b1));
      dir_rows[3]  = row(OP_MARK_DONE, 1023, 0,    1, 0, '0);
      dir_rows[4]  = row(OP_MARK_DONE, 5,    682,  1, 0, '0);
      dir_rows[5]  = row(OP_ADD_EDGE,  0,    0,    1, 1, edge_status(STATUS_ADDED));
      dir_rows[6]  = row(OP_ADD_EDGE,  0,    1023, 1, 1, edge_status(STATUS_ADDED));
      dir_rows[7]  = row(OP_MARK_DONE, 0,    341,  0, 0, '0);
      dir_rows[8]  = row(OP_ADD_EDGE,  512,  341,  1, 1, edge_status(STATUS_ADDED));
      dir_rows[9]  = row(OP_ADD_EDGE,  341,  682,  1, 1, edge_status(STATUS_ADDED));
      dir_rows[10] = row(OP_ADD_EDGE,  512,  682,  1, 1, edge_status(STATUS_ADDED));
      dir_rows[11] = row(OP_MARK_DONE, 512,  0,    0, 0, '0);
      dir_rows[12] = row(OP_MARK_DONE, 341,  1023, 0, 0, '0);
      dir_rows[13] = row(OP_MARK_DONE, 0,    0,    1, 0, '0);
      dir_rows[14] = row(OP_ADD_EDGE,  682,  512,  1, 1, edge_status(STATUS_ADDED));
      dir_rows[15] = row(OP_MARK_DONE, 682,  341,  0, 0, '0);

      repeat (8)
         @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_rsp,
                   dir_rows[i].exp_rsp);
      drain();

      // Random part: one full fanout first, then small graphs with noise
      req_bursty = 1'b1;
      rsp_bursty = 1'b1;
      fanout_episode();
      drain();
      while (random_items < RANDOM_ITEMS) begin
         req_bursty = $urandom_range(0, 1);
         rsp_bursty = $urandom_range(0, 1);
         graph_episode();
         if ($urandom_range(0, 3) == 0)
            drain();
      end

      // Wait out the last results and any stray ones
      quiet = 1'b1;
      drain();
      repeat (DRAIN_WAIT)
         @(posedge clock);

      $display("covered %0d edge adds (%0d dropped) and %0d mark-done transactions",
               n_adds, n_dropped, n_marks);
      $display("released %0d ready tasks, up to %0d from one mark done, %0d mismatches",
               n_ready, max_burst, err_count);
      if (err_count == 0 && exp_rsps.size() == 0)
         $display("dag_dependency_ready_tracker_top_tb: PASS");
      else
         $display("dag_dependency_ready_tracker_top_tb: FAIL");
      $finish;
   end

endmodule
